// ===== rtl/circumcircle_incircle_test_defines.svh =====
// ----------------------------------------------------------------------------
// circumcircle_incircle_test_defines
// Assertion macros used by the checker of the circumcircle block.
// ----------------------------------------------------------------------------
`ifndef CIRCUMCIRCLE_INCIRCLE_TEST_DEFINES_SVH
`define CIRCUMCIRCLE_INCIRCLE_TEST_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define CCIT_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication after a fixed number of cycles
`define CCIT_ASSERT_DLY(lbl, ante, n, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

// ===== rtl/ccit_pkg.sv =====
// ----------------------------------------------------------------------------
// ccit_pkg
// Widths, beat structs and register codes of the circumcircle block.
// ----------------------------------------------------------------------------
package ccit_pkg;

	localparam int CW      = 16;      // coordinate width
	localparam int DW      = CW + 1;  // coordinate difference
	localparam int SW      = 2 * CW;  // x*x + y*y, unsigned
	localparam int AW      = 36;      // twice area, signed
	localparam int NW      = 51;      // centre numerator, signed
	localparam int MW      = NW - 1;  // numerator magnitude
	localparam int QW      = 32;      // quotient / centre / root
	localparam int STEPS   = 32;      // divider and root steps
	localparam int LATENCY = 73;      // start to done, cycles

	typedef logic signed [CW-1:0] coord_t;

	typedef enum logic [0:0] {
		REG_TOL = 1'b0
	} reg_idx_t;

	typedef struct packed {
		coord_t x1;
		coord_t y1;
		coord_t qx;
		coord_t qy;
		logic   degen;
		logic   negx;
		logic   negy;
		logic   ovfx;
		logic   ovfy;
	} div_side_t;

	typedef struct packed {
		logic [MW-1:0] nx;
		logic [MW-1:0] ny;
		logic [AW-1:0] d;
		div_side_t     side;
	} div_in_t;

	typedef struct packed {
		logic [QW-1:0] qx;
		logic [QW-1:0] qy;
		div_side_t     side;
	} div_out_t;

	typedef struct packed {
		logic signed [QW-1:0] cx;
		logic signed [QW-1:0] cy;
		logic                 degen;
		logic                 in_circ;
		logic                 big;
	} sq_side_t;

	typedef struct packed {
		logic [2*QW-1:0] r2;
		sq_side_t        side;
	} sq_in_t;

	typedef struct packed {
		logic [QW-1:0] root;
		sq_side_t      side;
	} sq_out_t;

endpackage

// ===== rtl/circumcircle_incircle_test.sv =====
// ----------------------------------------------------------------------------
// circumcircle_incircle_test
// Circumcentre, circumradius and strict in-circle test of one triangle and
// one query point per beat, in signed fixed point.
// ----------------------------------------------------------------------------
// A beat enters when start is high; busy stays low, so one beat can enter in
// every clock cycle and several are in flight at once. Each result comes out
// on done for one cycle, in input order; the receiver cannot stall it, so
// it must take every result. A result passes the two bit-serial pipelines,
// 32 stages of the centre divider and 32 stages of the radius square root,
// plus 4 front stages (differences, products, sums, magnitudes), 4 back
// stages (saturation, distances, squares, compare) and the output register.
// A triangle whose absolute twice-area is at or below degenerate_tolerance
// (APB byte address 0, reset 0) reports degenerate, centre 0x7FFFFFFF on both
// axes, radius 0xFFFFFFFF and point_inside high. Otherwise the centre is
// truncated toward zero and saturated to 32 bits, the radius is the floor
// square root of the squared distance from vertex one to that centre
// (saturated), and point_inside is the strict compare of squared distances.
// Write the tolerance only while no beat is in flight.
// ----------------------------------------------------------------------------
module circumcircle_incircle_test
	import ccit_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// command side
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] vertex1_x,
	input  logic signed [15:0] vertex1_y,
	input  logic signed [15:0] vertex2_x,
	input  logic signed [15:0] vertex2_y,
	input  logic signed [15:0] vertex3_x,
	input  logic signed [15:0] vertex3_y,
	input  logic signed [15:0] query_x,
	input  logic signed [15:0] query_y,
	// result side
	output logic               done,
	output logic signed [31:0] centre_x,
	output logic signed [31:0] centre_y,
	output logic        [31:0] radius,
	output logic               degenerate,
	output logic               point_inside,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic        [2:0]  paddr,
	input  logic        [31:0] pwdata,
	output logic        [31:0] prdata,
	output logic               pready
);

	logic [31:0] tol_q;
	reg_idx_t    reg_idx;

	logic     f_valid, d_valid, b_valid, s_valid;
	div_in_t  f_data;
	div_out_t d_data;
	sq_in_t   b_data;
	sq_out_t  s_data;

	logic               done_q;
	logic signed [31:0] centre_x_q, centre_y_q;
	logic        [31:0] radius_q;
	logic               degenerate_q, point_inside_q;

	// fully pipelined: never holds off a beat
	assign busy   = 1'b0;
	assign pready = 1'b1;

	// word address; anything above the one register is ignored
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_TOL: tol_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TOL: prdata = tol_q;
			default: prdata = '0;
		endcase
	end

	ccit_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.x1       (vertex1_x),
		.y1       (vertex1_y),
		.x2       (vertex2_x),
		.y2       (vertex2_y),
		.x3       (vertex3_x),
		.y3       (vertex3_y),
		.qx       (query_x),
		.qy       (query_y),
		.tol      (tol_q),
		.out_valid(f_valid),
		.out_data (f_data)
	);

	ccit_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (f_valid),
		.in_data  (f_data),
		.out_valid(d_valid),
		.out_data (d_data)
	);

	ccit_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (d_valid),
		.in_data  (d_data),
		.out_valid(b_valid),
		.out_data (b_data)
	);

	ccit_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (b_valid),
		.in_data  (b_data),
		.out_valid(s_valid),
		.out_data (s_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= s_valid;
		end
	end

	// degenerate triangles override every field
	always_ff @(posedge clk) begin
		degenerate_q <= s_data.side.degen;
		if (s_data.side.degen) begin
			centre_x_q     <= {1'b0, {31{1'b1}}};
			centre_y_q     <= {1'b0, {31{1'b1}}};
			radius_q       <= '1;
			point_inside_q <= 1'b1;
		end else begin
			centre_x_q     <= s_data.side.cx;
			centre_y_q     <= s_data.side.cy;
			radius_q       <= s_data.side.big ? '1 : s_data.root;
			point_inside_q <= s_data.side.in_circ;
		end
	end

	assign done         = done_q;
	assign centre_x     = centre_x_q;
	assign centre_y     = centre_y_q;
	assign radius       = radius_q;
	assign degenerate   = degenerate_q;
	assign point_inside = point_inside_q;

endmodule

// ===== rtl/ccit_front.sv =====
// ----------------------------------------------------------------------------
// ccit_front
// Four stages: differences and squares, products, sums, magnitudes and
// divider setup.
// ----------------------------------------------------------------------------
module ccit_front
	import ccit_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  coord_t        x1,
	input  coord_t        y1,
	input  coord_t        x2,
	input  coord_t        y2,
	input  coord_t        x3,
	input  coord_t        y3,
	input  coord_t        qx,
	input  coord_t        qy,
	input  logic [31:0]   tol,
	output logic          out_valid,
	output div_in_t       out_data
);

	logic v_s1, v_s2, v_s3, v_s4;

	// stage 1
	coord_t x1_s1, y1_s1, x2_s1, x3_s1, qx_s1, qy_s1;
	logic signed [DW-1:0] dy23_s1, dy31_s1, dy12_s1, dx32_s1, dx13_s1, dx21_s1;
	logic [SW-1:0] s1_s1, s2_s1, s3_s1;

	// stage 2
	coord_t x1_s2, y1_s2, qx_s2, qy_s2;
	logic signed [DW+CW-1:0] a1_s2, a2_s2, a3_s2;
	logic signed [MW-1:0] px1_s2, px2_s2, px3_s2, py1_s2, py2_s2, py3_s2;

	// stage 3
	coord_t x1_s3, y1_s3, qx_s3, qy_s3;
	logic signed [AW-1:0] area_s3;
	logic signed [NW-1:0] nx_s3, ny_s3;

	// stage 4
	div_in_t d_s4;

	logic signed [SW-1:0] sq_x1, sq_y1, sq_x2, sq_y2, sq_x3, sq_y3;
	logic signed [AW-1:0] area_abs;
	logic signed [NW-1:0] nx_abs, ny_abs;
	logic [AW-1:0] dd;
	logic [MW-1:0] nxm, nym;

	assign sq_x1 = x1 * x1;
	assign sq_y1 = y1 * y1;
	assign sq_x2 = x2 * x2;
	assign sq_y2 = y2 * y2;
	assign sq_x3 = x3 * x3;
	assign sq_y3 = y3 * y3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		x1_s1   <= x1;
		y1_s1   <= y1;
		x2_s1   <= x2;
		x3_s1   <= x3;
		qx_s1   <= qx;
		qy_s1   <= qy;
		dy23_s1 <= DW'(y2) - DW'(y3);
		dy31_s1 <= DW'(y3) - DW'(y1);
		dy12_s1 <= DW'(y1) - DW'(y2);
		dx32_s1 <= DW'(x3) - DW'(x2);
		dx13_s1 <= DW'(x1) - DW'(x3);
		dx21_s1 <= DW'(x2) - DW'(x1);
		s1_s1   <= SW'($unsigned(sq_x1)) + SW'($unsigned(sq_y1));
		s2_s1   <= SW'($unsigned(sq_x2)) + SW'($unsigned(sq_y2));
		s3_s1   <= SW'($unsigned(sq_x3)) + SW'($unsigned(sq_y3));
	end

	always_ff @(posedge clk) begin
		x1_s2  <= x1_s1;
		y1_s2  <= y1_s1;
		qx_s2  <= qx_s1;
		qy_s2  <= qy_s1;
		a1_s2  <= x1_s1 * dy23_s1;
		a2_s2  <= x2_s1 * dy31_s1;
		a3_s2  <= x3_s1 * dy12_s1;
		px1_s2 <= $signed({1'b0, s1_s1}) * dy23_s1;
		px2_s2 <= $signed({1'b0, s2_s1}) * dy31_s1;
		px3_s2 <= $signed({1'b0, s3_s1}) * dy12_s1;
		py1_s2 <= $signed({1'b0, s1_s1}) * dx32_s1;
		py2_s2 <= $signed({1'b0, s2_s1}) * dx13_s1;
		py3_s2 <= $signed({1'b0, s3_s1}) * dx21_s1;
	end

	always_ff @(posedge clk) begin
		x1_s3   <= x1_s2;
		y1_s3   <= y1_s2;
		qx_s3   <= qx_s2;
		qy_s3   <= qy_s2;
		area_s3 <= AW'(a1_s2) + AW'(a2_s2) + AW'(a3_s2);
		nx_s3   <= NW'(px1_s2) + NW'(px2_s2) + NW'(px3_s2);
		ny_s3   <= NW'(py1_s2) + NW'(py2_s2) + NW'(py3_s2);
	end

	always_comb begin
		area_abs = area_s3[AW-1] ? -area_s3 : area_s3;
		nx_abs   = nx_s3[NW-1] ? -nx_s3 : nx_s3;
		ny_abs   = ny_s3[NW-1] ? -ny_s3 : ny_s3;
		dd       = {area_abs[AW-2:0], 1'b0};
		nxm      = nx_abs[MW-1:0];
		nym      = ny_abs[MW-1:0];
	end

	always_ff @(posedge clk) begin
		d_s4.nx         <= nxm;
		d_s4.ny         <= nym;
		d_s4.d          <= dd;
		d_s4.side.x1    <= x1_s3;
		d_s4.side.y1    <= y1_s3;
		d_s4.side.qx    <= qx_s3;
		d_s4.side.qy    <= qy_s3;
		d_s4.side.degen <= $unsigned(area_abs) <= AW'(tol);
		d_s4.side.negx  <= nx_s3[NW-1] ^ area_s3[AW-1];
		d_s4.side.negy  <= ny_s3[NW-1] ^ area_s3[AW-1];
		// quotient would need more than QW bits
		d_s4.side.ovfx  <= AW'(nxm[MW-1:QW]) >= dd;
		d_s4.side.ovfy  <= AW'(nym[MW-1:QW]) >= dd;
	end

	assign out_valid = v_s4;
	assign out_data  = d_s4;

endmodule

// ===== rtl/ccit_div.sv =====
// ----------------------------------------------------------------------------
// ccit_div
// Pipelined restoring divider, one quotient bit per stage, x and y side
// by side. Only the low QW quotient bits; larger quotients are flagged.
// ----------------------------------------------------------------------------
module ccit_div
	import ccit_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  div_in_t  in_data,
	output logic     out_valid,
	output div_out_t out_data
);

	logic            v_s   [0:STEPS-1];
	div_in_t         dat_s [0:STEPS-1];
	logic [AW-1:0]   rx_s  [0:STEPS-1];
	logic [AW-1:0]   ry_s  [0:STEPS-1];
	logic [QW-1:0]   qx_s  [0:STEPS-1];
	logic [QW-1:0]   qy_s  [0:STEPS-1];

	for (genvar k = 0; k < STEPS; k++) begin : g_stage
		logic          v_in;
		div_in_t       d_in;
		logic [AW-1:0] rx_in, ry_in;
		logic [QW-1:0] qx_in, qy_in;
		logic [AW:0]   tx, ty;

		if (k == 0) begin : g_first
			assign v_in  = in_valid;
			assign d_in  = in_data;
			assign rx_in = AW'(in_data.nx[MW-1:QW]);
			assign ry_in = AW'(in_data.ny[MW-1:QW]);
			assign qx_in = '0;
			assign qy_in = '0;
		end else begin : g_next
			assign v_in  = v_s[k-1];
			assign d_in  = dat_s[k-1];
			assign rx_in = rx_s[k-1];
			assign ry_in = ry_s[k-1];
			assign qx_in = qx_s[k-1];
			assign qy_in = qy_s[k-1];
		end

		assign tx = {rx_in, d_in.nx[QW-1-k]};
		assign ty = {ry_in, d_in.ny[QW-1-k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			dat_s[k] <= d_in;
			if (tx >= {1'b0, d_in.d}) begin
				rx_s[k] <= AW'(tx - {1'b0, d_in.d});
				qx_s[k] <= {qx_in[QW-2:0], 1'b1};
			end else begin
				rx_s[k] <= AW'(tx);
				qx_s[k] <= {qx_in[QW-2:0], 1'b0};
			end
			if (ty >= {1'b0, d_in.d}) begin
				ry_s[k] <= AW'(ty - {1'b0, d_in.d});
				qy_s[k] <= {qy_in[QW-2:0], 1'b1};
			end else begin
				ry_s[k] <= AW'(ty);
				qy_s[k] <= {qy_in[QW-2:0], 1'b0};
			end
		end
	end

	assign out_valid     = v_s[STEPS-1];
	assign out_data.qx   = qx_s[STEPS-1];
	assign out_data.qy   = qy_s[STEPS-1];
	assign out_data.side = dat_s[STEPS-1].side;

endmodule

// ===== rtl/ccit_back.sv =====
// ----------------------------------------------------------------------------
// ccit_back
// Centre saturation, distances to vertex one and query point, squares,
// sums and the strict inside compare. Four stages.
// ----------------------------------------------------------------------------
module ccit_back
	import ccit_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  div_out_t in_data,
	output logic     out_valid,
	output sq_in_t   out_data
);

	localparam int EW = QW + 2;

	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [QW-1:0] cx_s1, cy_s1, cx_s2, cy_s2, cx_s3, cy_s3;
	coord_t x1_s1, y1_s1, qx_s1, qy_s1;
	logic degen_s1, degen_s2, degen_s3;
	logic [QW-1:0] mx1_s2, my1_s2, mqx_s2, mqy_s2;
	logic [2*QW-1:0] sx1_s3, sy1_s3, sqx_s3, sqy_s3;
	sq_in_t o_s4;

	logic signed [EW-1:0] ex1, ey1, eqx, eqy;
	logic [2*QW:0] r2, d2;

	function automatic logic [QW-1:0] sat(input logic [QW-1:0] q, input logic ovf,
			input logic neg);
		logic [QW-1:0] r;
		if (neg) begin
			if (ovf || q > {1'b1, {(QW-1){1'b0}}})
				r = {1'b1, {(QW-1){1'b0}}};
			else
				r = -q;
		end else begin
			if (ovf || q[QW-1])
				r = {1'b0, {(QW-1){1'b1}}};
			else
				r = q;
		end
		return r;
	endfunction

	function automatic logic [QW-1:0] mag(input logic signed [EW-1:0] e);
		logic signed [EW-1:0] a;
		a = e[EW-1] ? -e : e;
		return a[QW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		cx_s1    <= $signed(sat(in_data.qx, in_data.side.ovfx, in_data.side.negx));
		cy_s1    <= $signed(sat(in_data.qy, in_data.side.ovfy, in_data.side.negy));
		x1_s1    <= in_data.side.x1;
		y1_s1    <= in_data.side.y1;
		qx_s1    <= in_data.side.qx;
		qy_s1    <= in_data.side.qy;
		degen_s1 <= in_data.side.degen;
	end

	assign ex1 = EW'(x1_s1) - EW'(cx_s1);
	assign ey1 = EW'(y1_s1) - EW'(cy_s1);
	assign eqx = EW'(qx_s1) - EW'(cx_s1);
	assign eqy = EW'(qy_s1) - EW'(cy_s1);

	always_ff @(posedge clk) begin
		mx1_s2   <= mag(ex1);
		my1_s2   <= mag(ey1);
		mqx_s2   <= mag(eqx);
		mqy_s2   <= mag(eqy);
		cx_s2    <= cx_s1;
		cy_s2    <= cy_s1;
		degen_s2 <= degen_s1;
	end

	always_ff @(posedge clk) begin
		sx1_s3   <= mx1_s2 * mx1_s2;
		sy1_s3   <= my1_s2 * my1_s2;
		sqx_s3   <= mqx_s2 * mqx_s2;
		sqy_s3   <= mqy_s2 * mqy_s2;
		cx_s3    <= cx_s2;
		cy_s3    <= cy_s2;
		degen_s3 <= degen_s2;
	end

	assign r2 = {1'b0, sx1_s3} + {1'b0, sy1_s3};
	assign d2 = {1'b0, sqx_s3} + {1'b0, sqy_s3};

	always_ff @(posedge clk) begin
		o_s4.r2           <= r2[2*QW-1:0];
		o_s4.side.big     <= r2[2*QW];
		o_s4.side.in_circ <= d2 < r2;
		o_s4.side.cx      <= cx_s3;
		o_s4.side.cy      <= cy_s3;
		o_s4.side.degen   <= degen_s3;
	end

	assign out_valid = v_s4;
	assign out_data  = o_s4;

endmodule

// ===== rtl/ccit_sqrt.sv =====
// ----------------------------------------------------------------------------
// ccit_sqrt
// Pipelined floor square root of a 2*QW bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module ccit_sqrt
	import ccit_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  sq_in_t  in_data,
	output logic    out_valid,
	output sq_out_t out_data
);

	localparam int RW = QW + 2;

	logic          v_s    [0:STEPS-1];
	sq_in_t        dat_s  [0:STEPS-1];
	logic [RW-1:0] rem_s  [0:STEPS-1];
	logic [QW-1:0] root_s [0:STEPS-1];

	for (genvar k = 0; k < STEPS; k++) begin : g_stage
		logic          v_in;
		sq_in_t        d_in;
		logic [RW-1:0] rem_in;
		logic [QW-1:0] root_in;
		logic [RW+1:0] t;
		logic [RW+1:0] trial;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign d_in    = in_data;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign v_in    = v_s[k-1];
			assign d_in    = dat_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		assign t     = {rem_in, d_in.r2[2*QW-1-2*k -: 2]};
		assign trial = {2'b00, root_in, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			dat_s[k] <= d_in;
			if (t >= trial) begin
				rem_s[k]  <= RW'(t - trial);
				root_s[k] <= {root_in[QW-2:0], 1'b1};
			end else begin
				rem_s[k]  <= RW'(t);
				root_s[k] <= {root_in[QW-2:0], 1'b0};
			end
		end
	end

	assign out_valid     = v_s[STEPS-1];
	assign out_data.root = root_s[STEPS-1];
	assign out_data.side = dat_s[STEPS-1].side;

endmodule

// ===== rtl/ccit_checker.sv =====
// ----------------------------------------------------------------------------
// ccit_checker
// Port-level checks of the circumcircle block, bound to the top level.
// ----------------------------------------------------------------------------
`include "circumcircle_incircle_test_defines.svh"

module ccit_checker
	import ccit_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic signed [15:0] vertex1_x,
	input logic signed [15:0] vertex1_y,
	input logic signed [15:0] vertex2_x,
	input logic signed [15:0] vertex2_y,
	input logic signed [15:0] vertex3_x,
	input logic signed [15:0] vertex3_y,
	input logic signed [15:0] query_x,
	input logic signed [15:0] query_y,
	input logic               done,
	input logic signed [31:0] centre_x,
	input logic signed [31:0] centre_y,
	input logic        [31:0] radius,
	input logic               degenerate,
	input logic               point_inside,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic        [2:0]  paddr,
	input logic        [31:0] pwdata,
	input logic        [31:0] prdata,
	input logic               pready
);

	`CCIT_ASSERT(a_degen_fields, done && degenerate, point_inside && radius == 32'hFFFFFFFF && centre_x == 32'sh7FFFFFFF && centre_y == 32'sh7FFFFFFF, "degenerate beat with wrong fields")
	`CCIT_ASSERT_DLY(a_latency, start && !busy, LATENCY, done, "accepted beat gave no result")
	`CCIT_ASSERT(a_no_orphan, done, $past(start && !busy, LATENCY), "result without a beat")

endmodule

bind circumcircle_incircle_test ccit_checker u_ccit_checker (.*);

// ===== bench/tb_circumcircle_incircle_test.sv =====
// ----------------------------------------------------------------------------
// tb_circumcircle_incircle_test
// Self-checking bench for the circumcircle and in-circle block.
// ----------------------------------------------------------------------------
// A directed table comes first: degenerate shapes with typed-in results,
// then right, tiny and extreme triangles checked by the bench's own exact
// model. Random beats follow, under several tolerance settings. The mix is
// wide-range, small-range, near-collinear, query-on-vertex and corner
// coordinates. Every accepted command pushes its predicted result. Each done
// beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_circumcircle_incircle_test;
	import ccit_pkg::*;

	localparam int RUN_ITEMS = 1950;
	localparam int WDOG_MAX  = 4000;

	typedef struct {
		coord_t x1, y1, x2, y2, x3, y3, qx, qy;
	} tri_beat_t;

	typedef struct {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic        [31:0] radius;
		logic               degen;
		logic               in_circ;
	} circle_res_t;

	// directed row: beat plus optional typed-in result
	typedef struct {
		tri_beat_t   beat;
		bit          typed;
		circle_res_t res;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [15:0] vertex1_x = '0, vertex1_y = '0, vertex2_x = '0, vertex2_y = '0;
	logic signed [15:0] vertex3_x = '0, vertex3_y = '0, query_x = '0, query_y = '0;
	logic               done;
	logic signed [31:0] centre_x, centre_y;
	logic        [31:0] radius;
	logic               degenerate, point_inside;
	logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic        [2:0]  paddr = '0;
	logic        [31:0] pwdata = '0;
	logic        [31:0] prdata;
	logic               pready;

	logic [31:0]  tol_shadow = '0;   // bench copy of degenerate_tolerance
	circle_res_t  pending_q[$];      // predicted results in flight
	bit           failed = 1'b0;
	int           idle_cycles = 0;
	bit           no_gaps = 1'b0;    // suppresses sender gaps

	circumcircle_incircle_test dut (.*);

	always #2 clk = ~clk;

	// --------------------------------------------------------------------
	// exact model: all math in 128-bit integers
	// --------------------------------------------------------------------
	function automatic logic signed [31:0] centre_quot(logic signed [127:0] num,
			logic signed [127:0] den);
		logic [127:0] nmag, dmag, q;
		bit neg;
		neg  = num[127] ^ den[127];
		nmag = num[127] ? -num : num;
		dmag = den[127] ? -den : den;
		q    = nmag / (dmag << 1);   // truncate toward zero
		if (neg) begin
			if (q > 128'h8000_0000) return 32'sh8000_0000;
			return 32'(32'd0 - q[31:0]);
		end
		if (q > 128'h7FFF_FFFF) return 32'sh7FFF_FFFF;
		return q[31:0];
	endfunction

	function automatic circle_res_t predict_circle(tri_beat_t b);
		logic signed [127:0] x1, y1, x2, y2, x3, y3, qx, qy;
		logic signed [127:0] area, s1, s2, s3, nx, ny, cxw, cyw, r2, d2;
		logic [127:0] amag, cand, root;
		circle_res_t r;
		x1 = b.x1; y1 = b.y1; x2 = b.x2; y2 = b.y2;
		x3 = b.x3; y3 = b.y3; qx = b.qx; qy = b.qy;
		area = x1 * (y2 - y3) + x2 * (y3 - y1) + x3 * (y1 - y2);
		amag = area[127] ? -area : area;
		if (amag <= {96'd0, tol_shadow}) begin
			r.cx = 32'sh7FFF_FFFF; r.cy = 32'sh7FFF_FFFF;
			r.radius = 32'hFFFF_FFFF; r.degen = 1'b1; r.in_circ = 1'b1;
			return r;
		end
		s1 = x1 * x1 + y1 * y1;
		s2 = x2 * x2 + y2 * y2;
		s3 = x3 * x3 + y3 * y3;
		nx = s1 * (y2 - y3) + s2 * (y3 - y1) + s3 * (y1 - y2);
		ny = s1 * (x3 - x2) + s2 * (x1 - x3) + s3 * (x2 - x1);
		r.cx = centre_quot(nx, area);
		r.cy = centre_quot(ny, area);
		cxw = r.cx; cyw = r.cy;
		r2 = (x1 - cxw) * (x1 - cxw) + (y1 - cyw) * (y1 - cyw);
		d2 = (qx - cxw) * (qx - cxw) + (qy - cyw) * (qy - cyw);
		// floor square root, 36 result bits, then saturate
		root = '0;
		for (int k = 35; k >= 0; k--) begin
			cand = root | (128'd1 << k);
			if (cand * cand <= $unsigned(r2)) root = cand;
		end
		r.radius  = (root > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
		r.degen   = 1'b0;
		r.in_circ = (d2 < r2);
		return r;
	endfunction

	// --------------------------------------------------------------------
	// APB register write, only called with nothing in flight
	// --------------------------------------------------------------------
	task automatic apb_write(reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 3'(idx) << 2; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == REG_TOL) tol_shadow = val;
	endtask

	// let the pipeline drain before touching the register
	task automatic drain;
		wait (pending_q.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// one command beat; expectation pushed at the accepting edge
	task automatic send_beat(tri_beat_t b, bit typed, circle_res_t tres);
		if (!no_gaps && $urandom_range(0, 99) < 15) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		vertex1_x <= b.x1; vertex1_y <= b.y1;
		vertex2_x <= b.x2; vertex2_y <= b.y2;
		vertex3_x <= b.x3; vertex3_y <= b.y3;
		query_x   <= b.qx; query_y   <= b.qy;
		start     <= 1'b1;
		do @(posedge clk); while (busy);
		pending_q.push_back(typed ? tres : predict_circle(b));
	endtask

	function automatic coord_t rnd_small();
		return coord_t'($urandom_range(0, 4000)) - 16'sd2000;
	endfunction

	function automatic coord_t rnd_wide();
		return coord_t'($urandom());
	endfunction

	function automatic coord_t rnd_corner();
		case ($urandom_range(0, 4))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return coord_t'($urandom());
		endcase
	endfunction

	function automatic tri_beat_t rnd_beat();
		tri_beat_t b;
		int k;
		case ($urandom_range(0, 9)) inside
			[0:3]: begin
				b.x1 = rnd_wide(); b.y1 = rnd_wide(); b.x2 = rnd_wide();
				b.y2 = rnd_wide(); b.x3 = rnd_wide(); b.y3 = rnd_wide();
				b.qx = rnd_wide(); b.qy = rnd_wide();
			end
			[4:6]: begin
				b.x1 = rnd_small(); b.y1 = rnd_small(); b.x2 = rnd_small();
				b.y2 = rnd_small(); b.x3 = rnd_small(); b.y3 = rnd_small();
				b.qx = rnd_small(); b.qy = rnd_small();
			end
			7: begin
				// on or near a line: tests tolerance and huge centres
				b.x1 = rnd_small(); b.y1 = rnd_small();
				b.x2 = rnd_small(); b.y2 = rnd_small();
				k = $urandom_range(0, 6) - 3;
				b.x3 = b.x1 + 16'(k) * (b.x2 - b.x1) + 16'($urandom_range(0, 2)) - 16'sd1;
				b.y3 = b.y1 + 16'(k) * (b.y2 - b.y1) + 16'($urandom_range(0, 2)) - 16'sd1;
				b.qx = rnd_small(); b.qy = rnd_small();
			end
			8: begin
				// query sits on vertex one: on the circle, so not strictly inside unless degenerate
				b.x1 = rnd_small(); b.y1 = rnd_small(); b.x2 = rnd_small();
				b.y2 = rnd_small(); b.x3 = rnd_small(); b.y3 = rnd_small();
				b.qx = b.x1; b.qy = b.y1;
			end
			default: begin
				b.x1 = rnd_corner(); b.y1 = rnd_corner(); b.x2 = rnd_corner();
				b.y2 = rnd_corner(); b.x3 = rnd_corner(); b.y3 = rnd_corner();
				b.qx = rnd_corner(); b.qy = rnd_corner();
			end
		endcase
		return b;
	endfunction

	// --------------------------------------------------------------------
	// result checker
	// --------------------------------------------------------------------
	task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
			failed = 1'b1;
		end
	endtask

	always @(posedge clk) begin
		circle_res_t e;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result beat, actual cx %h cy %h r %h",
					$time, centre_x, centre_y, radius);
				failed = 1'b1;
			end else begin
				e = pending_q.pop_front();
				check_field("centre_x", e.cx, centre_x);
				check_field("centre_y", e.cy, centre_y);
				check_field("radius", e.radius, radius);
				check_field("degenerate", 32'(e.degen), 32'(degenerate));
				check_field("point_inside", 32'(e.in_circ), 32'(point_inside));
			end
		end
	end

	// watchdog: cycles with neither a command nor a result accepted
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// --------------------------------------------------------------------
	// stimulus
	// --------------------------------------------------------------------
	initial begin
		dir_row_t    dirs[$];
		dir_row_t    row;
		circle_res_t degen_res;
		logic [31:0] tols[5];
		int          per_phase;

		degen_res.cx = 32'sh7FFF_FFFF; degen_res.cy = 32'sh7FFF_FFFF;
		degen_res.radius = 32'hFFFF_FFFF; degen_res.degen = 1'b1;
		degen_res.in_circ = 1'b1;

		// degenerate shapes with results typed in (tolerance 0)
		row.typed = 1'b1; row.res = degen_res;
		row.beat = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
		dirs.push_back(row);
		row.beat = '{16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd512, 16'sd512,
			16'sh7FFF, 16'sh8000};
		dirs.push_back(row);
		row.beat = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh8000, 16'sh8000};
		dirs.push_back(row);
		row.beat = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
			16'sh8000, 16'sd0, 16'sd0};
		dirs.push_back(row);
		// the rest go through the model
		row.typed = 1'b0;
		row.beat = '{16'sd0, 16'sd0, 16'sd512, 16'sd0, 16'sd0, 16'sd512,
			16'sd256, 16'sd256};   // right triangle, query at centre
		dirs.push_back(row);
		row.beat = '{16'sd0, 16'sd0, 16'sd512, 16'sd0, 16'sd0, 16'sd512,
			16'sh7FFF, 16'sh7FFF};  // query far outside
		dirs.push_back(row);
		row.beat = '{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1,
			16'sd0, 16'sd0};        // tiny, centre truncates to zero
		dirs.push_back(row);
		row.beat = '{16'sd0, 16'sd0, -16'sd3, 16'sd0, 16'sd0, -16'sd3,
			-16'sd1, -16'sd1};      // negative centre truncation
		dirs.push_back(row);
		row.beat = '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000,
			16'sh7FFF, 16'sh7FFF, 16'sh7FFF};  // largest triangle
		dirs.push_back(row);
		row.beat = '{16'sh8000, 16'sd0, 16'sh7FFF, 16'sd1, 16'sd0, 16'sd0,
			16'sd0, 16'sd0};        // nearly flat: large centre
		dirs.push_back(row);
		row.beat = '{16'sh8000, 16'sd0, 16'sh7FFF, -16'sd1, 16'sd0, 16'sd0,
			16'sd5, -16'sd5};       // nearly flat, bent the other way
		dirs.push_back(row);
		row.beat = '{16'sd256, 16'sd0, 16'sd0, 16'sd256, -16'sd256, 16'sd0,
			16'sd0, -16'sd256};     // query exactly on circle
		dirs.push_back(row);
		row.beat = '{-16'sd1, -16'sd1, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
			16'sh7FFF, 16'sh7FFF, 16'sh8000};
		dirs.push_back(row);

		tols = '{32'h0000_0000, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0100,
			$urandom()};
		per_phase = RUN_ITEMS / 5;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_write(REG_TOL, 32'h0000_0000);
		foreach (dirs[i])
			send_beat(dirs[i].beat, dirs[i].typed, dirs[i].res);
		start <= 1'b0;
		drain();

		// tolerance exactly at the right triangle's twice-area (512*512 = 0x40000)
		apb_write(REG_TOL, 32'h0004_0000);
		send_beat(dirs[4].beat, 1'b1, degen_res);
		start <= 1'b0;
		drain();

		for (int p = 0; p < 5; p++) begin
			apb_write(REG_TOL, tols[p]);
			for (int n = 0; n < per_phase; n++) begin
				// for part of one phase the sender adds no random gaps
				no_gaps = (p == 1 && n >= 50 && n < 300);
				// sender holds off until the pipe is empty
				if (n == per_phase / 2) begin
					start <= 1'b0;
					wait (pending_q.size() == 0);
					@(posedge clk);
				end
				send_beat(rnd_beat(), 1'b0, degen_res);
			end
			start <= 1'b0;
			no_gaps = 1'b0;
			drain();
		end

		if (!failed && pending_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			if (pending_q.size() != 0)
				$display("%0t: %0d results never arrived", $time, pending_q.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
